### sv/kll_pkg.sv
// Shared types, constants and character class tables for the kinsoku line layout block.
`timescale 1ns / 1ps
`default_nettype none

package kll_pkg;

  // Grid geometry
  localparam int COLS = 16;
  localparam int ROWS = 4;

  localparam int CODE_W  = 16;
  localparam int COL_W   = 5;   // columns up to 32
  localparam int ROW_W   = 3;   // rows up to 4, plus one past the end
  localparam int COUNT_W = 8;   // up to 255 cells
  localparam int SROW_W  = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  // Output queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  // Item kinds on the input tuser
  localparam logic FUNC_CHAR = 1'b0;
  localparam logic FUNC_END  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_COL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ROW = 1'b1;

  localparam logic [CODE_W-1:0] BLANK_CODE = 16'h0000;

  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic               last;
    logic               overflow;
    logic [COUNT_W-1:0] count;
  } result_t;

  // Characters that may not open a line (small kana, closing marks, punctuation)
  function automatic logic forbid_at_start(input logic [CODE_W-1:0] c);
    logic hit;
    hit = 1'b0;
    case (c)
      16'h82E1, 16'h82E3, 16'h82E5, 16'h82C1,
      16'h8142, 16'h8141, 16'h8145, 16'h8163,
      16'h8184, 16'h8178, 16'h8176, 16'h816A,
      16'h816E, 16'h8148, 16'h8149, 16'h817C,
      16'h815B, 16'h8383, 16'h8385, 16'h8387,
      16'h8362, 16'h8396, 16'h829F, 16'h82A1,
      16'h82A3, 16'h82A5, 16'h82A7, 16'h8340,
      16'h8342, 16'h8344, 16'h8346, 16'h8348,
      16'h8144, 16'h8160: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // Characters that may not close a line (opening brackets)
  function automatic logic forbid_at_end(input logic [CODE_W-1:0] c);
    logic hit;
    hit = 1'b0;
    case (c)
      16'h8183, 16'h8177, 16'h8175, 16'h816D, 16'h8169: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

`default_nettype wire

### sv/kinsoku_line_layout.sv
// Top level of the kinsoku line layout block: layout state, line break rules, output queue.
`timescale 1ns / 1ps
`default_nettype none

// A result is queued when its input transaction is accepted; results ahead of it go first.
// Throughput: one input transaction per cycle while the 4-entry output queue has room
// for two results; items that cause two results drain at one result per cycle, so the
// output port sets the sustained rate.
// Reset (rst, synchronous): empties the queue, clears start registers, opens a fresh run.
module kinsoku_line_layout (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write port
  input  wire logic        cfg_we,
  input  wire logic [kll_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [kll_pkg::CFG_DATA_W-1:0] cfg_data,
  // Input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [15:0] char_code
  input  wire logic        s_tuser,   // [0] func
  // Result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [15:0] out_code, [23:16] code_count
  output logic             m_tlast,   // last
  output logic             m_tuser    // [0] overflow
);

  localparam logic [kll_pkg::COL_W:0]   COLS_X   = (kll_pkg::COL_W + 1)'(kll_pkg::COLS);
  localparam logic [kll_pkg::COL_W-1:0] LAST_COL = kll_pkg::COL_W'(kll_pkg::COLS - 1);
  localparam logic [kll_pkg::ROW_W-1:0] ROWS_X   = kll_pkg::ROW_W'(kll_pkg::ROWS);

  // Configuration registers
  logic [kll_pkg::COL_W-1:0]  start_col;
  logic [kll_pkg::SROW_W-1:0] start_row;

  // Layout state
  logic [kll_pkg::COL_W-1:0]   col_pos, col_pos_next;
  logic [kll_pkg::ROW_W-1:0]   row_pos, row_pos_next;
  logic [kll_pkg::COUNT_W-1:0] cell_count, cell_count_next;
  logic [kll_pkg::CODE_W-1:0]  held_code, held_code_next;
  logic                        held_valid, held_valid_next;
  logic                        halted, halted_next;
  logic                        fresh, fresh_next;

  // Output queue
  kll_pkg::result_t               fifo_mem [kll_pkg::FIFO_DEPTH];
  logic [kll_pkg::FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [kll_pkg::FIFO_CNT_W-1:0] fifo_cnt;

  logic in_hs, out_hs;
  logic [1:0] push_n;
  kll_pkg::result_t res0, res1;

  // Working position after reload at the first character of a run
  logic [kll_pkg::COL_W-1:0]   col_eff;
  logic [kll_pkg::ROW_W-1:0]   row_eff;
  logic [kll_pkg::COUNT_W-1:0] cnt_eff;
  logic                        hv_eff;
  logic [kll_pkg::COL_W:0]     col_inc;
  logic [kll_pkg::CODE_W-1:0]  held_out;

  // Two free slots are needed: one character can cause two results
  assign s_tready = (fifo_cnt <= kll_pkg::FIFO_CNT_W'(kll_pkg::FIFO_DEPTH - 2));
  assign in_hs    = s_tvalid && s_tready;
  assign out_hs   = m_tvalid && m_tready;

  assign m_tvalid = (fifo_cnt != '0);
  assign m_tdata  = {fifo_mem[rd_ptr].count, fifo_mem[rd_ptr].code};
  assign m_tlast  = fifo_mem[rd_ptr].last;
  assign m_tuser  = fifo_mem[rd_ptr].overflow;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_col <= '0;
      start_row <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kll_pkg::CFG_START_COL: start_col <= cfg_data;
        kll_pkg::CFG_START_ROW: start_row <= cfg_data[kll_pkg::SROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Layout decision for one accepted item
  always_comb begin
    col_pos_next    = col_pos;
    row_pos_next    = row_pos;
    cell_count_next = cell_count;
    held_code_next  = held_code;
    held_valid_next = held_valid;
    halted_next     = halted;
    fresh_next      = fresh;
    push_n          = 2'd0;
    res0            = '0;
    res1            = '0;

    // Reload the cursor at the first character; a start column past the grid
    // begins the row below.
    if (fresh) begin
      hv_eff  = 1'b0;
      cnt_eff = '0;
      if ({1'b0, start_col} >= COLS_X) begin
        col_eff = '0;
        row_eff = kll_pkg::ROW_W'(start_row) + 1'b1;
      end else begin
        col_eff = start_col;
        row_eff = kll_pkg::ROW_W'(start_row);
      end
    end else begin
      hv_eff  = held_valid;
      cnt_eff = cell_count;
      col_eff = col_pos;
      row_eff = row_pos;
    end
    held_out = hv_eff ? held_code : kll_pkg::BLANK_CODE;
    col_inc  = {1'b0, col_eff} + 1'b1;

    if (in_hs) begin
      if (s_tuser == kll_pkg::FUNC_END) begin
        if (halted) begin
          // End of an overflowed run: swallowed, next run starts clean
          halted_next = 1'b0;
          fresh_next  = 1'b1;
        end else begin
          res0            = '{code: held_out, last: 1'b1, overflow: 1'b0, count: cnt_eff};
          push_n          = 2'd1;
          cell_count_next = cnt_eff;
          held_valid_next = 1'b0;
          held_code_next  = kll_pkg::BLANK_CODE;
          fresh_next      = 1'b1;
        end
      end else if (!halted) begin
        fresh_next = 1'b0;
        if (row_eff >= ROWS_X) begin
          // Screen full
          res0            = '{code: held_out, last: 1'b1, overflow: 1'b1, count: cnt_eff};
          push_n          = 2'd1;
          halted_next     = 1'b1;
          cell_count_next = cnt_eff;
          held_valid_next = 1'b0;
          held_code_next  = kll_pkg::BLANK_CODE;
        end else if (col_eff == '0 && hv_eff && kll_pkg::forbid_at_start(s_tdata)) begin
          // Pull the previous cell down behind a blank pad
          res0            = '{code: kll_pkg::BLANK_CODE, last: 1'b0, overflow: 1'b0, count: '0};
          res1            = '{code: held_code, last: 1'b0, overflow: 1'b0, count: '0};
          push_n          = 2'd2;
          held_code_next  = s_tdata;
          held_valid_next = 1'b1;
          cell_count_next = cnt_eff + kll_pkg::COUNT_W'(2);
          if ((kll_pkg::COL_W + 1)'(2) >= COLS_X) begin
            col_pos_next = '0;
            row_pos_next = row_eff + 1'b1;
          end else begin
            col_pos_next = kll_pkg::COL_W'(2);
            row_pos_next = row_eff;
          end
        end else if (col_eff == LAST_COL && kll_pkg::forbid_at_end(s_tdata)) begin
          if (row_eff + 1'b1 >= ROWS_X) begin
            // No next line for the pushed character
            res0            = '{code: held_out, last: 1'b1, overflow: 1'b1, count: cnt_eff};
            push_n          = 2'd1;
            halted_next     = 1'b1;
            cell_count_next = cnt_eff;
            held_valid_next = 1'b0;
            held_code_next  = kll_pkg::BLANK_CODE;
          end else begin
            // Push the opening mark to the next line behind a blank pad
            if (hv_eff) begin
              res0   = '{code: held_code, last: 1'b0, overflow: 1'b0, count: '0};
              res1   = '{code: kll_pkg::BLANK_CODE, last: 1'b0, overflow: 1'b0, count: '0};
              push_n = 2'd2;
            end else begin
              res0   = '{code: kll_pkg::BLANK_CODE, last: 1'b0, overflow: 1'b0, count: '0};
              push_n = 2'd1;
            end
            held_code_next  = s_tdata;
            held_valid_next = 1'b1;
            cell_count_next = cnt_eff + kll_pkg::COUNT_W'(2);
            row_pos_next    = row_eff + 1'b1;
            col_pos_next    = kll_pkg::COL_W'(1);
          end
        end else begin
          // Ordinary character: release the held cell, hold this one
          if (hv_eff) begin
            res0   = '{code: held_code, last: 1'b0, overflow: 1'b0, count: '0};
            push_n = 2'd1;
          end
          held_code_next  = s_tdata;
          held_valid_next = 1'b1;
          cell_count_next = cnt_eff + 1'b1;
          if (col_inc >= COLS_X) begin
            col_pos_next = '0;
            row_pos_next = row_eff + 1'b1;
          end else begin
            col_pos_next = col_inc[kll_pkg::COL_W-1:0];
            row_pos_next = row_eff;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos    <= '0;
      row_pos    <= '0;
      cell_count <= '0;
      held_code  <= '0;
      held_valid <= 1'b0;
      halted     <= 1'b0;
      fresh      <= 1'b1;
    end else begin
      col_pos    <= col_pos_next;
      row_pos    <= row_pos_next;
      cell_count <= cell_count_next;
      held_code  <= held_code_next;
      held_valid <= held_valid_next;
      halted     <= halted_next;
      fresh      <= fresh_next;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
    end else begin
      wr_ptr   <= wr_ptr + kll_pkg::FIFO_PTR_W'(push_n);
      rd_ptr   <= rd_ptr + kll_pkg::FIFO_PTR_W'(out_hs);
      fifo_cnt <= fifo_cnt + kll_pkg::FIFO_CNT_W'(push_n) - kll_pkg::FIFO_CNT_W'(out_hs);
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo_mem[wr_ptr] <= res0;
    end
    if (push_n == 2'd2) begin
      fifo_mem[wr_ptr + 1'b1] <= res1;
    end
  end

  // Checks
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_cnt <= kll_pkg::FIFO_CNT_W'(kll_pkg::FIFO_DEPTH))
    else $error("output queue overrun");

  a_fresh_empty: assert property (@(posedge clk) disable iff (rst)
    fresh |-> !held_valid)
    else $error("held cell left over at run start");

  a_halt_empty: assert property (@(posedge clk) disable iff (rst)
    halted |-> !held_valid)
    else $error("held cell kept after overflow");

  a_char_clears_fresh: assert property (@(posedge clk) disable iff (rst)
    (in_hs && s_tuser == kll_pkg::FUNC_CHAR) |=> !fresh)
    else $error("character did not open a run");

  a_halt_last: assert property (@(posedge clk) disable iff (rst)
    $rose(halted) |-> (fifo_cnt != '0))
    else $error("overflow without a final result");

endmodule

`default_nettype wire

### verif/tb.sv
// Self-checking testbench for the kinsoku line layout block.
`timescale 1ns / 1ps

// Tracks the layout state the block should be in, predicts the cells every
// input transaction must produce, and checks each result against them.
class layout_tracker;
  logic [4:0]  cur_start_col;
  logic [1:0]  cur_start_row;
  int unsigned col;
  int unsigned row;
  int unsigned cells;
  logic [15:0] held;
  bit          held_ok;
  bit          halted;
  bit          fresh;
  int unsigned sent_items;
  int unsigned faults;
  kll_pkg::result_t cells_due[$];

  // Closing marks, small kana, punctuation: never allowed at a line start.
  logic [15:0] no_line_start[34] = '{
    16'h82E1, 16'h82E3, 16'h82E5, 16'h82C1, 16'h8142, 16'h8141, 16'h8145,
    16'h8163, 16'h8184, 16'h8178, 16'h8176, 16'h816A, 16'h816E, 16'h8148,
    16'h8149, 16'h817C, 16'h815B, 16'h8383, 16'h8385, 16'h8387, 16'h8362,
    16'h8396, 16'h829F, 16'h82A1, 16'h82A3, 16'h82A5, 16'h82A7, 16'h8340,
    16'h8342, 16'h8344, 16'h8346, 16'h8348, 16'h8144, 16'h8160};
  // Opening brackets: never allowed at a line end.
  logic [15:0] no_line_end[5] = '{16'h8183, 16'h8177, 16'h8175, 16'h816D, 16'h8169};

  function new();
    cur_start_col = '0;
    cur_start_row = '0;
    col = 0;
    row = 0;
    cells = 0;
    held = kll_pkg::BLANK_CODE;
    held_ok = 0;
    halted = 0;
    fresh = 1;
    sent_items = 0;
    faults = 0;
  endfunction

  function void load_cursor(logic [4:0] c, logic [1:0] r);
    cur_start_col = c;
    cur_start_row = r;
  endfunction

  function bit listed(logic [15:0] c, bit at_start);
    bit hit;
    hit = 0;
    if (at_start) begin
      foreach (no_line_start[i]) if (no_line_start[i] == c) hit = 1;
    end else begin
      foreach (no_line_end[i]) if (no_line_end[i] == c) hit = 1;
    end
    return hit;
  endfunction

  function void due(logic [15:0] c, logic lst, logic ovf, logic [7:0] cnt);
    kll_pkg::result_t r;
    r.code = c;
    r.last = lst;
    r.overflow = ovf;
    r.count = cnt;
    cells_due.push_back(r);
  endfunction

  // Flush the held cell as the final cell of the run.
  function void close_run(logic ovf);
    due(held_ok ? held : kll_pkg::BLANK_CODE, 1'b1, ovf, cells[7:0]);
    held_ok = 0;
    held = kll_pkg::BLANK_CODE;
  endfunction

  function void place_item(logic func, logic [15:0] c);
    sent_items++;
    if (func == kll_pkg::FUNC_END) begin
      if (halted) begin
        // end item only closes an overflowed run, nothing is emitted
        halted = 0;
        fresh = 1;
        return;
      end
      if (fresh) cells = 0;
      close_run(1'b0);
      fresh = 1;
      return;
    end
    if (halted) return;
    if (fresh) begin
      fresh = 0;
      cells = 0;
      held_ok = 0;
      held = kll_pkg::BLANK_CODE;
      if (cur_start_col >= kll_pkg::COLS) begin
        col = 0;
        row = cur_start_row + 1;
      end else begin
        col = cur_start_col;
        row = cur_start_row;
      end
    end
    if (row >= kll_pkg::ROWS) begin
      halted = 1;
      close_run(1'b1);
      return;
    end
    if (col == 0 && held_ok && listed(c, 1'b1)) begin
      // pull the previous cell down, pad the line above
      due(kll_pkg::BLANK_CODE, 1'b0, 1'b0, 8'd0);
      due(held, 1'b0, 1'b0, 8'd0);
      held = c;
      cells += 2;
      col = 2;
      if (col >= kll_pkg::COLS) begin
        col = 0;
        row++;
      end
      return;
    end
    if (col == kll_pkg::COLS - 1 && listed(c, 1'b0)) begin
      if (row + 1 >= kll_pkg::ROWS) begin
        halted = 1;
        close_run(1'b1);
        return;
      end
      // push the bracket to the next line behind a pad
      if (held_ok) due(held, 1'b0, 1'b0, 8'd0);
      due(kll_pkg::BLANK_CODE, 1'b0, 1'b0, 8'd0);
      held = c;
      held_ok = 1;
      cells += 2;
      row++;
      col = 1;
      return;
    end
    if (held_ok) due(held, 1'b0, 1'b0, 8'd0);
    held = c;
    held_ok = 1;
    cells += 1;
    col++;
    if (col >= kll_pkg::COLS) begin
      col = 0;
      row++;
    end
  endfunction

  function void check_cell(logic [15:0] c, logic lst, logic ovf, logic [7:0] cnt);
    kll_pkg::result_t want;
    if (cells_due.size() == 0) begin
      $error("unexpected cell: out_code %h last %b overflow %b code_count %0d",
             c, lst, ovf, cnt);
      faults++;
      return;
    end
    want = cells_due.pop_front();
    if (c !== want.code) begin
      $error("out_code: expected %h, got %h", want.code, c);
      faults++;
    end
    if (lst !== want.last) begin
      $error("last: expected %b, got %b", want.last, lst);
      faults++;
    end
    if (ovf !== want.overflow) begin
      $error("overflow: expected %b, got %b", want.overflow, ovf);
      faults++;
    end
    if (cnt !== want.count) begin
      $error("code_count: expected %0d, got %0d", want.count, cnt);
      faults++;
    end
  endfunction
endclass

module tb;

  // Long receiver hold-off used to back the block up into its input.
  localparam int CHOKE_CYCLES = 80;
  localparam int ITEM_TARGET  = 650;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [kll_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [kll_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [15:0]                    s_tdata;   // [15:0] char_code
  logic                           s_tuser;   // [0] func
  logic                           m_tvalid;
  logic                           m_tready;
  logic [23:0]                    m_tdata;   // [15:0] out_code, [23:16] code_count
  logic                           m_tlast;   // last
  logic                           m_tuser;   // [0] overflow

  layout_tracker sb;
  bit            steady;      // no idling on either side while set
  bit            choke_req;   // asks the receiver for one long hold-off

  kinsoku_line_layout DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #10_000_000;
    $display("kinsoku_line_layout: mismatch");
    $finish;
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 20);
  endfunction

  // Character mix biased toward the line-break classes and their neighbors.
  function automatic logic [15:0] pick_char();
    int unsigned r;
    logic [15:0] c;
    r = $urandom_range(0, 99);
    if (r < 25) c = sb.no_line_start[$urandom_range(0, 33)];
    else if (r < 35) c = sb.no_line_end[$urandom_range(0, 4)];
    else if (r < 40) c = sb.no_line_start[$urandom_range(0, 33)] ^ 16'h0100;
    else if (r < 42) c = 16'h0000;
    else if (r < 44) c = 16'hFFFF;
    else c = 16'($urandom_range(0, 65535));
    return c;
  endfunction

  // Offer one item; return once the transaction has happened. tvalid is left
  // high so back-to-back items keep the bus busy.
  task automatic send_item(input logic func, input logic [15:0] c);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= c;
    do @(posedge clk); while (!s_tready);
    sb.place_item(func, c);
  endtask

  // Drain: stop offering, wait for every predicted cell, then allow for the
  // registered state update of an item that produces nothing.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.cells_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Both cursor registers, one write per cycle.
  task automatic set_cursor(input logic [4:0] c, input logic [1:0] r);
    cfg_we    <= 1'b1;
    cfg_index <= kll_pkg::CFG_START_COL;
    cfg_data  <= c;
    @(posedge clk);
    cfg_index <= kll_pkg::CFG_START_ROW;
    cfg_data  <= {3'b000, r};
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.load_cursor(c, r);
  endtask

  // One text: a run of characters closed by an end item. Long runs spill
  // past the screen; sometimes a stray empty run follows.
  task automatic random_text();
    int unsigned n;
    n = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 90) : $urandom_range(0, 24);
    repeat (n) send_item(kll_pkg::FUNC_CHAR, pick_char());
    send_item(kll_pkg::FUNC_END, 16'($urandom_range(0, 65535)));
    if ($urandom_range(0, 9) == 0)
      send_item(kll_pkg::FUNC_END, 16'($urandom_range(0, 65535)));
  endtask

  // Result side: random stalls, plus the long hold-off on request.
  initial begin
    int unsigned n;
    m_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (choke_req) begin
        m_tready <= 1'b0;
        repeat (CHOKE_CYCLES) @(posedge clk);
        choke_req = 0;
      end else if (steady || $urandom_range(0, 9) < 6) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        n = pick_gap();
        m_tready <= 1'b0;
        repeat (n == 0 ? 1 : n) @(posedge clk);
      end
    end
  end

  // Every result transaction goes to the tracker.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_cell(m_tdata[15:0], m_tlast, m_tuser, m_tdata[23:16]);
  end

  initial begin
    int unsigned chokes;
    sb = new();
    steady = 0;
    choke_req = 0;
    chokes = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = kll_pkg::FUNC_CHAR;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty run, code extremes at the reset cursor.
    send_item(kll_pkg::FUNC_END, 16'hFFFF);
    send_item(kll_pkg::FUNC_CHAR, 16'h0000);
    send_item(kll_pkg::FUNC_CHAR, 16'hFFFF);
    send_item(kll_pkg::FUNC_END, 16'h0000);
    settle();
    // Line-start-forbidden mark right after a wrap pulls the last cell down.
    set_cursor(5'd15, 2'd0);
    send_item(kll_pkg::FUNC_CHAR, 16'h3042);
    send_item(kll_pkg::FUNC_CHAR, 16'h82E1);
    send_item(kll_pkg::FUNC_CHAR, 16'h8160);
    send_item(kll_pkg::FUNC_END, 16'h0000);
    settle();
    // Opening bracket in the last column moves to the next line.
    set_cursor(5'd15, 2'd1);
    send_item(kll_pkg::FUNC_CHAR, 16'h8169);
    send_item(kll_pkg::FUNC_CHAR, 16'h1234);
    send_item(kll_pkg::FUNC_END, 16'h0000);
    settle();
    // Start column past the grid on the last row: overflow on the first
    // character, the rest of the text is dropped.
    set_cursor(5'd31, 2'd3);
    send_item(kll_pkg::FUNC_CHAR, 16'h3042);
    send_item(kll_pkg::FUNC_CHAR, 16'h4E00);
    send_item(kll_pkg::FUNC_END, 16'h0000);
    settle();
    // Opening bracket at the very last cell of the screen.
    set_cursor(5'd15, 2'd3);
    send_item(kll_pkg::FUNC_CHAR, 16'h8183);
    send_item(kll_pkg::FUNC_END, 16'h0000);
    settle();
    // Start column 16 wraps to the next row; a forbidden mark with nothing
    // held is laid out as usual.
    set_cursor(5'd16, 2'd2);
    send_item(kll_pkg::FUNC_CHAR, 16'h82E1);
    send_item(kll_pkg::FUNC_END, 16'h0000);

    // Random texts with occasional cursor changes between them.
    while (sb.sent_items < ITEM_TARGET) begin
      if ($urandom_range(0, 3) == 0) begin
        settle();
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: set_cursor(5'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
          6, 7:             set_cursor(5'($urandom_range(14, 15)), 2'($urandom_range(0, 3)));
          default:          set_cursor(5'($urandom_range(16, 31)), 2'($urandom_range(0, 3)));
        endcase
      end
      steady = ($urandom_range(0, 4) == 0);
      // Twice in the run, stall the output long enough to back up the input.
      if ((chokes == 0 && sb.sent_items >= 200) || (chokes == 1 && sb.sent_items >= 450)) begin
        choke_req = 1;
        chokes++;
      end
      random_text();
    end

    steady = 0;
    settle();
    repeat (10) @(posedge clk);
    if (sb.faults == 0 && sb.cells_due.size() == 0) begin
      $display("kinsoku_line_layout: match");
    end else begin
      $display("kinsoku_line_layout: mismatch");
    end
    $finish;
  end

endmodule
